/* hdl/skt_pkg.sv */
// Shared definitions for the sorted key table: field widths, operation and
// status codes, the controller state type and the command broadcast to cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 7;
	localparam int OCC_W     = 8;
	localparam int DEPTH_DEF = 128;
	localparam int S_DATA_W  = 96;
	localparam int M_DATA_W  = 48;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} skt_state_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} skt_cmd_t;

endpackage

`default_nettype wire

/* hdl/sorted_key_table.sv */
// Sorted key table: a row of record cells kept in ascending key order, with
// a small controller, a result encoder and an output register.
// Depends on skt_pkg, skt_cell and skt_result.
//
// Usage: one operation enters on the slave stream (tuser holds the opcode,
// tdata the key and the value) and one result leaves on the master stream
// (tuser holds the status, tdata the position, matched value and occupancy).
// On the accepting edge every cell compares its key with the new key. Once
// the output register is free, the cells shift up (insert) or down (delete)
// in one step and the result is written to the output register at the same
// edge. A new operation is taken only after both the compare stage and the
// update stage of the cell row are through with the last one.
// While a result waits in the output register the next operation is still
// accepted and compared; its update waits until the output register is free.
// Opcode 3 acts as a search. A full table refuses inserts with a status.
// Reset empties the table at once by clearing the valid flag of each cell;
// stored keys and values are not cleared and are never read while invalid.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0: key [63:0], value [95:64].
	input  wire logic [skt_pkg::S_DATA_W-1:0] s_tdata,
	// Fields from bit 0: opcode [1:0].
	input  wire logic [skt_pkg::OP_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// Fields from bit 0: position [6:0], found_value [38:7], occupancy [46:39].
	output logic [skt_pkg::M_DATA_W-1:0]      m_tdata,
	// Fields from bit 0: status [1:0].
	output logic [skt_pkg::STATUS_W-1:0]      m_tuser
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	skt_pkg::skt_state_t state_q, state_d;

	logic [skt_pkg::OP_W-1:0]     op_q;
	logic [skt_pkg::KEY_W-1:0]    key_q;
	logic [skt_pkg::VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_d;
	logic                         m_tvalid_q;
	logic [skt_pkg::M_DATA_W-1:0] m_tdata_q;
	logic [skt_pkg::STATUS_W-1:0] m_tuser_q;

	logic                         accept;
	logic                         advance;
	logic                         full;
	logic                         ins_go;
	logic                         del_go;
	logic [skt_pkg::STATUS_W-1:0] status;
	logic [skt_pkg::POS_W-1:0]    pos;
	logic [skt_pkg::VAL_W-1:0]    fval;
	skt_pkg::skt_cmd_t            cmd;

	logic [DEPTH-1:0]          c_valid;
	logic [DEPTH-1:0]          c_less;
	logic [DEPTH-1:0]          c_first;
	logic [DEPTH-1:0]          c_hit;
	logic [skt_pkg::KEY_W-1:0] c_key [DEPTH];
	logic [skt_pkg::VAL_W-1:0] c_val [DEPTH];

	logic [IDX_W-1:0]          r_idx;
	logic                      r_found;
	logic [skt_pkg::VAL_W-1:0] r_val;

	assign accept  = s_tvalid && s_tready;
	assign advance = (state_q == skt_pkg::S_EXEC) && (!m_tvalid_q || m_tready);
	assign full    = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			skt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = skt_pkg::S_EXEC;
				end
			end
			skt_pkg::S_EXEC: begin
				if (advance) begin
					state_d = skt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[skt_pkg::KEY_W-1:0];
			val_q <= s_tdata[skt_pkg::KEY_W +: skt_pkg::VAL_W];
		end
	end

	always_comb begin
		ins_go  = 1'b0;
		del_go  = 1'b0;
		status  = skt_pkg::ST_DONE;
		pos     = skt_pkg::POS_W'(r_idx);
		fval    = r_val;
		count_d = count_q;
		unique case (op_q)
			skt_pkg::OP_INSERT: begin
				fval = '0;
				if (full) begin
					status = skt_pkg::ST_FULL;
					pos    = '0;
				end else begin
					ins_go  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			skt_pkg::OP_DELETE: begin
				if (!r_found) begin
					status = skt_pkg::ST_NOT_FOUND;
					pos    = '0;
					fval   = '0;
				end else begin
					del_go  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (!r_found) begin
					status = skt_pkg::ST_NOT_FOUND;
					pos    = '0;
					fval   = '0;
				end
			end
		endcase
	end

	assign cmd.ins = advance && ins_go;
	assign cmd.del = advance && del_go;
	assign cmd.key = key_q;
	assign cmd.val = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tuser_q <= status;
			m_tdata_q <= {1'b0, skt_pkg::OCC_W'(count_d), fval, pos};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      p_less;
		logic                      p_valid;
		logic [skt_pkg::KEY_W-1:0] p_key;
		logic [skt_pkg::VAL_W-1:0] p_val;
		logic                      n_valid;
		logic [skt_pkg::KEY_W-1:0] n_key;
		logic [skt_pkg::VAL_W-1:0] n_val;

		if (i == 0) begin : g_head
			assign p_less  = 1'b1;
			assign p_valid = 1'b0;
			assign p_key   = '0;
			assign p_val   = '0;
		end else begin : g_body
			assign p_less  = c_less[i-1];
			assign p_valid = c_valid[i-1];
			assign p_key   = c_key[i-1];
			assign p_val   = c_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = '0;
			assign n_val   = '0;
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_key   = c_key[i+1];
			assign n_val   = c_val[i+1];
		end

		skt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_cmp   (accept),
			.cmp_key    (s_tdata[skt_pkg::KEY_W-1:0]),
			.cmd        (cmd),
			.prev_less  (p_less),
			.prev_valid (p_valid),
			.prev_key   (p_key),
			.prev_val   (p_val),
			.next_valid (n_valid),
			.next_key   (n_key),
			.next_val   (n_val),
			.valid      (c_valid[i]),
			.key        (c_key[i]),
			.val        (c_val[i]),
			.less       (c_less[i]),
			.first      (c_first[i]),
			.hit        (c_hit[i])
		);
	end

	skt_result #(
		.DEPTH (DEPTH)
	) u_result (
		.first     (c_first),
		.hit       (c_hit),
		.val       (c_val),
		.idx       (r_idx),
		.found     (r_found),
		.found_val (r_val)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("record count exceeds table depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(c_valid) == int'(count_q))
		else $error("valid cells disagree with record count");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::S_EXEC |-> $onehot0(c_first))
		else $error("more than one insertion boundary");

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::S_EXEC |-> $onehot0(c_hit))
		else $error("more than one first match");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the table by one");
`endif

endmodule

`default_nettype wire

/* hdl/skt_cell.sv */
// One cell of the sorted key table: holds a single record, compares it with
// the requested key and shifts records to or from its neighbours.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load_cmp,
	input  wire logic [skt_pkg::KEY_W-1:0] cmp_key,
	input  wire skt_pkg::skt_cmd_t         cmd,
	input  wire logic                      prev_less,
	input  wire logic                      prev_valid,
	input  wire logic [skt_pkg::KEY_W-1:0] prev_key,
	input  wire logic [skt_pkg::VAL_W-1:0] prev_val,
	input  wire logic                      next_valid,
	input  wire logic [skt_pkg::KEY_W-1:0] next_key,
	input  wire logic [skt_pkg::VAL_W-1:0] next_val,
	output logic                           valid,
	output logic [skt_pkg::KEY_W-1:0]      key,
	output logic [skt_pkg::VAL_W-1:0]      val,
	output logic                           less,
	output logic                           first,
	output logic                           hit
);

	logic                      valid_q;
	logic [skt_pkg::KEY_W-1:0] key_q;
	logic [skt_pkg::VAL_W-1:0] val_q;
	logic                      less_q;
	logic                      eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			less_q  <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (load_cmp) begin
				less_q <= valid_q && (key_q < cmp_key);
				eq_q   <= valid_q && (key_q == cmp_key);
			end
			if (cmd.ins && !less_q) begin
				valid_q <= prev_less ? 1'b1 : prev_valid;
			end else if (cmd.del && !less_q) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !less_q) begin
			key_q <= prev_less ? cmd.key : prev_key;
			val_q <= prev_less ? cmd.val : prev_val;
		end else if (cmd.del && !less_q) begin
			key_q <= next_key;
			val_q <= next_val;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign val   = val_q;
	assign less  = less_q;
	assign first = !less_q && prev_less;
	assign hit   = eq_q && first;

endmodule

`default_nettype wire

/* hdl/skt_result.sv */
// Result encoder of the sorted key table: turns the one-hot boundary and
// match flags of the cells into an index, a found flag and the matched value.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_result #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input  wire logic [DEPTH-1:0]          first,
	input  wire logic [DEPTH-1:0]          hit,
	input  wire logic [skt_pkg::VAL_W-1:0] val [DEPTH],
	output logic [$clog2(DEPTH)-1:0]       idx,
	output logic                           found,
	output logic [skt_pkg::VAL_W-1:0]      found_val
);

	localparam int IDX_W = $clog2(DEPTH);

	always_comb begin
		idx       = '0;
		found_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				idx = idx | IDX_W'(i);
			end
			if (hit[i]) begin
				found_val = found_val | val[i];
			end
		end
	end

	assign found = |hit;

endmodule

`default_nettype wire
